/* design/isrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package isrf_pkg;

    // Frame geometry
    localparam int FRAME_ROWS = 32;
    localparam int FRAME_COLS = 32;
    localparam int ROW_W      = $clog2(FRAME_ROWS);
    localparam int COL_W      = $clog2(FRAME_COLS);

    // Pixel and threshold width
    localparam int PIX_W = 8;

    // Sum of up to four neighbors
    localparam int SUM_W = PIX_W + 2;

    // floor(s / 3) = (s * RECIP3) >> RECIP3_SH for any sum of three pixels
    localparam int RECIP3    = 683;
    localparam int RECIP3_SH = 11;
    localparam int PROD_W    = 2 * SUM_W;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // What the back end does with one input word
    typedef enum logic [1:0] {
        K_STORE  = 2'd0,   // first row: keep the original only
        K_FILTER = 2'd1,   // filter the pixel above, emit one word
        K_FINAL  = 2'd2    // as K_FILTER, then flush the last row
    } t_kind;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic             has_up;
        t_kind            kind;
    } t_cmd;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_FLUSH = 1'b1
    } t_back_state;

endpackage

`default_nettype wire

/* design/isrf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module isrf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [isrf_pkg::PIX_W-1:0]        i_pixel,
    output logic                              o_stall,
    input  logic                              i_full,
    output logic                              o_push,
    output isrf_pkg::t_cmd                    o_cmd
);
    import isrf_pkg::*;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             is_last_px;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Classify the incoming word by its raster position
    always_comb begin
        is_last_px = (r_row == ROW_W'(FRAME_ROWS - 1)) &&
                     (r_col == COL_W'(FRAME_COLS - 1));
        o_cmd.pixel  = i_pixel;
        o_cmd.col    = r_col;
        o_cmd.has_up = (r_row > ROW_W'(1));
        if (r_row == '0) begin
            o_cmd.kind = K_STORE;
        end else if (is_last_px) begin
            o_cmd.kind = K_FINAL;
        end else begin
            o_cmd.kind = K_FILTER;
        end
    end

    // Raster position of the next word
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (o_push) begin
            if (is_last_px) begin
                n_row = '0;
                n_col = '0;
            end else if (r_col == COL_W'(FRAME_COLS - 1)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

`default_nettype wire

/* design/isrf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module isrf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  isrf_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output isrf_pkg::t_cmd o_data
);
    import isrf_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QPTR_W + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/isrf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module isrf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [isrf_pkg::PIX_W-1:0] i_threshold,
    input  logic                       i_cmd_valid,
    input  isrf_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_pop,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [isrf_pkg::PIX_W-1:0] o_out_pixel,
    output logic                       o_run_last,
    output logic                       o_frame_end
);
    import isrf_pkg::*;

    // Row delay lines: index 0 is the newest word
    logic [PIX_W-1:0] r_orig [FRAME_COLS];
    logic [PIX_W-1:0] r_filt [FRAME_COLS];

    t_back_state      r_state, n_state;
    logic [COL_W-1:0] r_fcol, n_fcol;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_run_last;
    logic             r_frame_end;

    logic             out_free;
    logic             shift_o;
    logic             shift_f;
    logic             load;
    logic             ld_last;
    logic             ld_fend;
    logic [PIX_W-1:0] orig_in;

    logic [COL_W-1:0] col;
    logic             has_left, has_right, has_up, has_down;
    logic [PIX_W-1:0] ctr, v_left, v_right, v_up, v_down;
    logic [PIX_W-1:0] d_left, d_right, d_up, d_down;
    logic             spike;
    logic [SUM_W-1:0] sum;
    logic [2:0]       cnt;
    logic [PROD_W-1:0] prod3;
    logic [PIX_W-1:0] mean;
    logic [PIX_W-1:0] filt_val;

    assign out_free = !r_out_valid || !i_stall;

    // Neighborhood of the pixel being filtered
    always_comb begin
        if (r_state == ST_FLUSH) begin
            col      = r_fcol;
            has_up   = 1'b1;
            has_down = 1'b0;
            v_down   = '0;
        end else begin
            col      = i_cmd.col;
            has_up   = i_cmd.has_up;
            has_down = 1'b1;
            v_down   = i_cmd.pixel;
        end
        has_left  = (col != '0);
        has_right = (col != COL_W'(FRAME_COLS - 1));
        ctr       = r_orig[FRAME_COLS-1];
        v_right   = r_orig[FRAME_COLS-2];
        v_left    = r_filt[0];
        v_up      = r_filt[FRAME_COLS-1];
    end

    // Spike test and neighbor mean
    always_comb begin
        d_left  = (ctr > v_left)  ? ctr - v_left  : v_left  - ctr;
        d_right = (ctr > v_right) ? ctr - v_right : v_right - ctr;
        d_up    = (ctr > v_up)    ? ctr - v_up    : v_up    - ctr;
        d_down  = (ctr > v_down)  ? ctr - v_down  : v_down  - ctr;

        spike = (!has_left  || (d_left  > i_threshold)) &&
                (!has_right || (d_right > i_threshold)) &&
                (!has_up    || (d_up    > i_threshold)) &&
                (!has_down  || (d_down  > i_threshold));

        sum = (has_left  ? SUM_W'(v_left)  : SUM_W'(0)) +
              (has_right ? SUM_W'(v_right) : SUM_W'(0)) +
              (has_up    ? SUM_W'(v_up)    : SUM_W'(0)) +
              (has_down  ? SUM_W'(v_down)  : SUM_W'(0));
        cnt = 3'(has_left) + 3'(has_right) + 3'(has_up) + 3'(has_down);

        prod3 = PROD_W'(sum) * PROD_W'(RECIP3);
        case (cnt)
            3'd3:    mean = prod3[RECIP3_SH +: PIX_W];
            3'd4:    mean = sum[2 +: PIX_W];
            default: mean = sum[1 +: PIX_W];
        endcase

        filt_val = spike ? mean : ctr;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (i_cmd_valid && (i_cmd.kind == K_FINAL) && out_free) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free && (r_fcol == COL_W'(FRAME_COLS - 1))) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // Datapath controls
    always_comb begin
        o_cmd_pop = 1'b0;
        shift_o   = 1'b0;
        shift_f   = 1'b0;
        load      = 1'b0;
        ld_last   = 1'b0;
        ld_fend   = 1'b0;
        orig_in   = i_cmd.pixel;
        n_fcol    = '0;
        case (r_state)
            ST_RUN: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == K_STORE) begin
                        o_cmd_pop = 1'b1;
                        shift_o   = 1'b1;
                    end else if (out_free) begin
                        o_cmd_pop = 1'b1;
                        shift_o   = 1'b1;
                        shift_f   = 1'b1;
                        load      = 1'b1;
                        ld_last   = (i_cmd.kind == K_FILTER);
                    end
                end
            end
            ST_FLUSH: begin
                n_fcol = r_fcol;
                if (out_free) begin
                    shift_o = 1'b1;
                    orig_in = '0;
                    shift_f = 1'b1;
                    load    = 1'b1;
                    ld_last = (r_fcol == COL_W'(FRAME_COLS - 1));
                    ld_fend = ld_last;
                    n_fcol  = r_fcol + COL_W'(1);
                end
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_fcol      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fcol  <= n_fcol;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_pixel <= filt_val;
            r_run_last  <= ld_last;
            r_frame_end <= ld_fend;
        end
    end

    // Row delay lines
    always_ff @(posedge i_clk) begin
        if (shift_o) begin
            for (int i = FRAME_COLS - 1; i > 0; i--) begin
                r_orig[i] <= r_orig[i-1];
            end
            r_orig[0] <= orig_in;
        end
        if (shift_f) begin
            for (int i = FRAME_COLS - 1; i > 0; i--) begin
                r_filt[i] <= r_filt[i-1];
            end
            r_filt[0] <= filt_val;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_run_last  = r_run_last;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire

/* design/image_spike_removal_filter_core.sv */
// Impulse noise removal, 4-neighbor rule, on a 32 x 32 frame in raster order.
// Input channel: i_valid / o_stall carry one pixel word per accepted edge.
// Output channel: o_valid / i_stall carry filtered words, also raster order.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the spike threshold
// (reset value 1); write it only while the block is idle.
// Words of the first row are stored and give no output. Every later input
// word releases the filtered pixel one row above it; the last word of the
// frame also releases the whole last row (33 output words for that input).
// A filtered word passes the command queue and then the output register;
// o_valid rises once it is registered there, when nothing waits ahead of it.
// Throughput: one word per cycle unless the output stalls; the end-of-frame
// flush holds the back end for the whole last row, while the command queue
// (4 words) fills, then the input stalls. The filter step is combinational, as
// the left neighbor of each pixel is the filtered result of the one before.
// A stalled output word holds; the back end keeps working as long as its
// output register can be refilled, and new input waits in the queue.
// Reset (synchronous, active low) returns the raster position to the start
// of a frame, empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module image_spike_removal_filter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [isrf_pkg::PIX_W-1:0] i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [isrf_pkg::PIX_W-1:0] i_pixel,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [isrf_pkg::PIX_W-1:0] o_out_pixel,
    output logic                       o_run_last,
    output logic                       o_frame_end
);
    import isrf_pkg::*;

    logic [PIX_W-1:0] r_threshold;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    t_cmd             push_cmd;
    t_cmd             head_cmd;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= PIX_W'(1);
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    isrf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_stall (o_stall),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (push_cmd)
    );

    isrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_cmd)
    );

    isrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (q_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_pixel (o_out_pixel),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import isrf_pkg::*;

    // Cycles with no accepted word on either side before the run is abandoned
    localparam int IDLE_LIMIT   = 4000;
    // Settling time after the last expected word, covers store-only words in flight
    localparam int SETTLE_TICKS = 4;
    // Output words seen before the receiver's forced long hold-off
    localparam int HOLD_TRIGGER = 60;
    localparam int HOLD_TICKS   = 300;

    // First-row words: extremes and alternating bit patterns
    localparam logic [PIX_W-1:0] DIRECTED_PIXELS [25] = '{
        8'd0,   8'd255, 8'd0,   8'd255, 8'd1,   8'd254, 8'd128, 8'd127, 8'd85,
        8'd170, 8'd0,   8'd0,   8'd255, 8'd255, 8'd2,   8'd253, 8'd64,  8'd192,
        8'd16,  8'd240, 8'd0,   8'd255, 8'd100, 8'd200, 8'd255
    };

    typedef enum int {RX_FREE, RX_RANDOM, RX_TOGGLE, RX_HOLD} t_rx_mode;
    typedef enum int {STYLE_UNIFORM, STYLE_SPIKY, STYLE_EXTREME} t_pixel_style;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             run_last;
        logic             frame_end;
    } t_filtered_word;

    // Spike filter predictor plus the queue of filtered words still owed
    class spike_scoreboard;
        logic [PIX_W-1:0] filtered_row [FRAME_COLS];
        logic [PIX_W-1:0] original_row [FRAME_COLS];
        int               row_pos;
        int               col_pos;
        logic [PIX_W-1:0] threshold;
        t_filtered_word   expected_words [$];
        int               errors;
        int               frames_done;

        function new();
            row_pos     = 0;
            col_pos     = 0;
            threshold   = PIX_W'(1);
            errors      = 0;
            frames_done = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // 4-neighbor rule: replace by the truncated mean only if every
        // existing neighbor differs by more than the threshold
        function logic [PIX_W-1:0] filter_at(int col, bit has_up, bit has_down,
                                             logic [PIX_W-1:0] below);
            logic [PIX_W-1:0] nb [4];
            int               count;
            int               sum;
            int               diff;
            int               center;
            bit               spike;
            count  = 0;
            sum    = 0;
            spike  = 1'b1;
            center = int'(original_row[col]);
            if (col > 0) begin
                nb[count] = filtered_row[col-1];
                count++;
            end
            if (has_up) begin
                nb[count] = filtered_row[col];
                count++;
            end
            if (col + 1 < FRAME_COLS) begin
                nb[count] = original_row[col+1];
                count++;
            end
            if (has_down) begin
                nb[count] = below;
                count++;
            end
            for (int i = 0; i < count; i++) begin
                diff = center - int'(nb[i]);
                if (diff < 0) diff = -diff;
                if (diff <= int'(threshold)) spike = 1'b0;
                sum += int'(nb[i]);
            end
            if (spike && count > 0) return PIX_W'(sum / count);
            return PIX_W'(center);
        endfunction

        function void push_word(logic [PIX_W-1:0] px, logic rl, logic fe);
            t_filtered_word w;
            w.pixel     = px;
            w.run_last  = rl;
            w.frame_end = fe;
            expected_words.push_back(w);
        endfunction

        // One accepted input word: filter the pixel above it, and on the
        // last word of the frame also flush the bottom row
        function void note_pixel(logic [PIX_W-1:0] px);
            logic [PIX_W-1:0] v;
            bit               last_px;
            last_px = (row_pos == FRAME_ROWS - 1) && (col_pos == FRAME_COLS - 1);
            if (row_pos > 0) begin
                v = filter_at(col_pos, row_pos > 1, 1'b1, px);
                filtered_row[col_pos] = v;
                push_word(v, !last_px, 1'b0);
            end
            original_row[col_pos] = px;
            if (last_px) begin
                for (int k = 0; k < FRAME_COLS; k++) begin
                    v = filter_at(k, 1'b1, 1'b0, '0);
                    filtered_row[k] = v;
                    push_word(v, k == FRAME_COLS - 1, k == FRAME_COLS - 1);
                end
                row_pos = 0;
                col_pos = 0;
                frames_done++;
            end else begin
                col_pos++;
                if (col_pos == FRAME_COLS) begin
                    col_pos = 0;
                    row_pos++;
                end
            end
        endfunction

        function void check_word(logic [PIX_W-1:0] px, logic rl, logic fe);
            t_filtered_word w;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word pixel=%0d run_last=%0b frame_end=%0b",
                                 px, rl, fe));
            end else begin
                w = expected_words.pop_front();
                if (w.pixel !== px || w.run_last !== rl || w.frame_end !== fe) begin
                    report($sformatf({"word mismatch: expected pixel=%0d run_last=%0b ",
                                      "frame_end=%0b, got pixel=%0d run_last=%0b ",
                                      "frame_end=%0b"},
                                     w.pixel, w.run_last, w.frame_end, px, rl, fe));
                end
            end
        endfunction

        function void check_drained();
            if (expected_words.size() != 0) begin
                report($sformatf("%0d filtered words never arrived", expected_words.size()));
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [PIX_W-1:0] i_cfg_wr_data = '0;
    logic             i_valid       = 1'b0;
    logic [PIX_W-1:0] i_pixel       = '0;
    logic             i_stall       = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [PIX_W-1:0] o_out_pixel;
    logic             o_run_last;
    logic             o_frame_end;

    spike_scoreboard sb = new();
    int              words_out      = 0;
    int              idle_cycles    = 0;
    int              items_sent     = 0;
    int              smooth_level   = 128;
    bit              long_hold_done = 1'b0;

    image_spike_removal_filter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_pixel   (o_out_pixel),
        .o_run_last    (o_run_last),
        .o_frame_end   (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Handshake monitor and watchdog; outputs checked before the input is noted
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_word(o_out_pixel, o_run_last, o_frame_end);
            words_out++;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_pixel(i_pixel);
        end
        if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver stall pattern; one long hold-off while the sender keeps going
    initial begin : receiver
        t_rx_mode mode;
        int       seg_len;
        int       pick;
        forever begin
            if (!long_hold_done && words_out >= HOLD_TRIGGER) begin
                mode           = RX_HOLD;
                seg_len        = HOLD_TICKS;
                long_hold_done = 1'b1;
            end else begin
                pick    = $urandom_range(0, 19);
                seg_len = $urandom_range(8, 120);
                if (pick < 8) mode = RX_FREE;
                else if (pick < 14) mode = RX_RANDOM;
                else if (pick < 19) mode = RX_TOGGLE;
                else begin
                    mode    = RX_HOLD;
                    seg_len = $urandom_range(100, 250);
                end
            end
            repeat (seg_len) begin
                @(posedge i_clk);
                case (mode)
                    RX_FREE:   i_stall <= 1'b0;
                    RX_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
                    RX_TOGGLE: i_stall <= ~i_stall;
                    default:   i_stall <= 1'b1;
                endcase
            end
        end
    end

    // Drive one pixel word and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic idle_input(input int ticks);
        i_valid <= 1'b0;
        i_pixel <= PIX_W'($urandom);
        repeat (ticks) @(posedge i_clk);
    endtask

    // Wait until every owed word is out and the block has settled
    task automatic drain_output();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [PIX_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.threshold = value;
    endtask

    // Pixel content: uniform noise, a smooth field with sparse spikes, or
    // mostly rail values
    function automatic logic [PIX_W-1:0] next_pixel(input t_pixel_style style);
        int value;
        int step;
        value = 0;
        step  = $urandom_range(0, 4);
        smooth_level += step - 2;
        if (smooth_level < 0) smooth_level = 0;
        if (smooth_level > 253) smooth_level = 253;
        case (style)
            STYLE_UNIFORM: value = $urandom_range(0, 255);
            STYLE_SPIKY: begin
                if ($urandom_range(0, 7) == 0) begin
                    if ($urandom_range(0, 1) == 1) value = 255 - int'($urandom_range(0, 10));
                    else value = $urandom_range(0, 10);
                end else begin
                    value = smooth_level + int'($urandom_range(0, 2));
                end
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       value = 0;
                    1:       value = 255;
                    default: value = smooth_level;
                endcase
            end
        endcase
        return PIX_W'(value);
    endfunction

    initial begin : stimulus
        int               phase;
        int               phase_len;
        int               burst_left;
        bit               gap_free;
        t_pixel_style     style;
        logic [PIX_W-1:0] new_threshold;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed first-row words, back to back; no output expected
        foreach (DIRECTED_PIXELS[i]) send_pixel(DIRECTED_PIXELS[i]);

        // Random phases; the first runs on the reset threshold
        phase = 0;
        while (items_sent < 500) begin
            if (phase > 0) begin
                drain_output();
                case (phase)
                    1:       new_threshold = 8'd0;
                    2:       new_threshold = 8'd255;
                    3:       new_threshold = 8'd30;
                    default: new_threshold = ($urandom_range(0, 3) == 0) ?
                                             PIX_W'($urandom_range(0, 255)) :
                                             PIX_W'($urandom_range(0, 40));
                endcase
                write_threshold(new_threshold);
            end
            style      = t_pixel_style'($urandom_range(0, 2));
            gap_free   = ($urandom_range(0, 3) == 0);
            phase_len  = $urandom_range(150, 450);
            burst_left = 0;
            repeat (phase_len) begin
                if (items_sent >= 500) break;
                if (!gap_free && burst_left <= 0) begin
                    idle_input($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 48);
                end
                send_pixel(next_pixel(style));
                burst_left--;
            end
            phase++;
        end

        drain_output();
        repeat (20) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* image_spike_removal_filter_core.f */
design/isrf_pkg.sv
design/isrf_front.sv
design/isrf_queue.sv
design/isrf_back.sv
design/image_spike_removal_filter_core.sv
tb/sv/tb_top.sv
